[rtl/sorted_range_table_lookup_assert.svh]
// Assertion macros for the sorted range table lookup block.
`ifndef SORTED_RANGE_TABLE_LOOKUP_ASSERT_SVH
`define SORTED_RANGE_TABLE_LOOKUP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define SRTL_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define SRTL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SRTL_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define SRTL_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

[rtl/srtl_pkg.sv]
// Shared types and constants for the sorted range table lookup block.
package srtl_pkg;
    localparam int BASE_W  = 64;
    localparam int SIZE_W  = 32;
    localparam int HELD_W  = 9;
    localparam int STAT_W  = 2;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_QUERY = 2'd1,
        S_DONE  = 2'd2
    } state_t;

    typedef struct packed {
        logic done;
        logic hit;
    } search_res_t;

    typedef struct packed {
        logic              hit;
        status_t           status;
        logic [HELD_W-1:0] held;
    } result_t;
endpackage

[rtl/srtl_cell.sv]
// One table cell: holds a range, shifts up on insert, evaluates a query.
module srtl_cell #(
    parameter int IDX = 0,
    parameter int CW  = 9
) (
    input  logic                        aclk,
    input  logic                        ins_en,
    input  logic                        q_en,
    input  logic [CW-1:0]               count,
    input  logic [srtl_pkg::BASE_W-1:0] new_base,
    input  logic [srtl_pkg::SIZE_W-1:0] new_size,
    input  logic [srtl_pkg::BASE_W-1:0] q_addr,
    input  logic                        prev_gt,
    input  logic [srtl_pkg::BASE_W-1:0] prev_base,
    input  logic [srtl_pkg::SIZE_W-1:0] prev_size,
    output logic                        gt,
    output logic [srtl_pkg::BASE_W-1:0] base_out,
    output logic [srtl_pkg::SIZE_W-1:0] size_out,
    output logic                        contain,
    output logic                        less
);
    import srtl_pkg::*;

    logic [BASE_W-1:0] base_reg, base_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic              contain_reg, contain_next;
    logic              less_reg, less_next;
    logic [BASE_W-1:0] top_addr;
    logic              below, at_end;

    assign below    = CW'(IDX) < count;
    assign at_end   = CW'(IDX) == count;
    assign gt       = below && (base_reg > new_base);
    assign top_addr = base_reg + {{(BASE_W-SIZE_W){1'b0}}, size_reg};

    always_comb begin
        base_next    = base_reg;
        size_next    = size_reg;
        contain_next = contain_reg;
        less_next    = less_reg;
        if (ins_en) begin
            if (prev_gt) begin
                base_next = prev_base;
                size_next = prev_size;
            end else if (gt || at_end) begin
                base_next = new_base;
                size_next = new_size;
            end
        end
        if (q_en) begin
            contain_next = (q_addr >= base_reg) && (q_addr < top_addr);
            less_next    = q_addr < base_reg;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg    <= base_next;
        size_reg    <= size_next;
        contain_reg <= contain_next;
        less_reg    <= less_next;
    end

    assign base_out = base_reg;
    assign size_out = size_reg;
    assign contain  = contain_reg;
    assign less     = less_reg;
endmodule

[rtl/srtl_search.sv]
// Iterative binary search over per-cell hit and below flags.
module srtl_search #(
    parameter int N  = 256,
    parameter int CW = 9
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [CW-1:0]        count,
    input  logic [N-1:0]         contain_v,
    input  logic [N-1:0]         less_v,
    output srtl_pkg::search_res_t res
);
    import srtl_pkg::*;

    localparam int IW  = CW + 1;
    localparam int IXW = (N > 1) ? $clog2(N) : 1;

    logic signed [IW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic signed [IW-1:0] diff, mid;
    logic                 active_reg, active_next;
    logic                 empty, found;

    assign diff  = hi_reg - lo_reg;
    assign mid   = lo_reg + (diff >>> 1);
    assign empty = lo_reg > hi_reg;
    assign found = !empty && contain_v[mid[IXW-1:0]];

    always_comb begin
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        active_next = active_reg;
        res.done    = 1'b0;
        res.hit     = 1'b0;
        if (start) begin
            lo_next     = '0;
            hi_next     = $signed({1'b0, count}) - IW'(1);
            active_next = 1'b1;
        end else if (active_reg) begin
            if (empty || found) begin
                res.done    = 1'b1;
                res.hit     = found;
                active_next = 1'b0;
            end else if (less_v[mid[IXW-1:0]]) begin
                hi_next = mid - IW'(1);
            end else begin
                lo_next = mid + IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
        end
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end
endmodule

[rtl/sorted_range_table_lookup.sv]
// Top level of the sorted range table lookup block.
// Sorted range table: a chain of TABLE_ENTRIES cells holds ranges (64-bit base,
// 32-bit size) in ascending base order. op 0 clears, op 1 inserts (after equal
// bases; skipped with status 1 if base or size is zero, dropped with status 2
// when full), op 2 queries an address by binary search, reporting hit when the
// visited entry has base <= address < base+size (64-bit wrap). One result per
// transaction. Clear, insert and unused op set their result as they are accepted,
// and the whole chain shifts at once. A query first registers every cell's
// compare of the address, then the search unit takes one search step per cycle,
// one flag read per step, until it hits or runs empty. Each result then moves to
// the output register once that is free. One item is worked on at a time; a new
// item is accepted while the previous result still waits in the output register.
module sorted_range_table_lookup #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [63:0] range_base, [95:64] range_size, [159:96] query_address
    input  logic [159:0] s_tdata,
    // [1:0] op
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] hit, [2:1] status, [11:3] entries_held, [15:12] zero
    output logic [15:0]  m_tdata
);
    import srtl_pkg::*;
    `include "sorted_range_table_lookup_assert.svh"

    localparam int N  = TABLE_ENTRIES;
    localparam int CW = $clog2(N + 1);

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    result_t           res_reg, res_next;
    result_t           out_reg, out_next;
    logic              m_tvalid_reg, m_tvalid_next;

    logic              accept;
    op_t               op;
    logic [BASE_W-1:0] in_base, q_addr;
    logic [SIZE_W-1:0] in_size;
    logic              is_empty, is_full, ins_en, q_en;
    search_res_t       sres;

    logic [N:0]        gt_v;
    logic [BASE_W-1:0] base_v [0:N];
    logic [SIZE_W-1:0] size_v [0:N];
    logic [N-1:0]      contain_v, less_v;

    assign s_tready = state_reg == S_IDLE;
    assign accept   = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser);
    assign in_base  = s_tdata[63:0];
    assign in_size  = s_tdata[95:64];
    assign q_addr   = s_tdata[159:96];
    assign is_empty = (in_base == '0) || (in_size == '0);
    assign is_full  = count_reg >= CW'(N);
    assign ins_en   = accept && (op == OP_INSERT) && !is_empty && !is_full;
    assign q_en     = accept && (op == OP_QUERY);

    // Cell chain: cell i takes its lower neighbor's entry when that one moves up.
    assign gt_v[0]   = 1'b0;
    assign base_v[0] = in_base;
    assign size_v[0] = in_size;

    for (genvar i = 0; i < N; i++) begin : g_cell
        srtl_cell #(.IDX(i), .CW(CW)) u_cell (
            .aclk      (aclk),
            .ins_en    (ins_en),
            .q_en      (q_en),
            .count     (count_reg),
            .new_base  (in_base),
            .new_size  (in_size),
            .q_addr    (q_addr),
            .prev_gt   (gt_v[i]),
            .prev_base (base_v[i]),
            .prev_size (size_v[i]),
            .gt        (gt_v[i+1]),
            .base_out  (base_v[i+1]),
            .size_out  (size_v[i+1]),
            .contain   (contain_v[i]),
            .less      (less_v[i])
        );
    end

    srtl_search #(.N(N), .CW(CW)) u_search (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (q_en),
        .count     (count_reg),
        .contain_v (contain_v),
        .less_v    (less_v),
        .res       (sres)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_next.hit    = 1'b0;
                    res_next.status = ST_DONE;
                    res_next.held   = HELD_W'(count_reg);
                    state_next      = S_DONE;
                    unique case (op)
                        OP_CLEAR: begin
                            count_next    = '0;
                            res_next.held = '0;
                        end
                        OP_INSERT: begin
                            if (is_empty) begin
                                res_next.status = ST_EMPTY;
                            end else if (is_full) begin
                                res_next.status = ST_FULL;
                            end else begin
                                count_next    = count_reg + CW'(1);
                                res_next.held = HELD_W'(count_reg + CW'(1));
                            end
                        end
                        OP_QUERY: begin
                            state_next = S_QUERY;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_QUERY: begin
                if (sres.done) begin
                    res_next.hit = sres.hit;
                    state_next   = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_next      = res_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, out_reg.held, out_reg.status, out_reg.hit};

    `SRTL_ASSERT_IMPL(a_count_max, aclk, aresetn, 1'b1, count_reg <= CW'(N))
    `SRTL_ASSERT_NEXT(a_query_enters, aclk, aresetn, q_en, state_reg == S_QUERY)
    `SRTL_ASSERT_IMPL(a_hit_status, aclk, aresetn, m_tvalid && m_tdata[0], m_tdata[2:1] == 2'd0)
    `SRTL_ASSERT_NEXT(a_out_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `SRTL_ASSERT_IMPL(a_search_state, aclk, aresetn, sres.done, state_reg == S_QUERY)
endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the sorted range table lookup block.
module tb;
    import srtl_pkg::*;

    localparam int DEPTH      = 256;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        op_t         op;
        logic [63:0] base;
        logic [31:0] size;
        logic [63:0] addr;
    } req_t;

    typedef struct {
        logic        hit;
        status_t     status;
        logic [8:0]  held;
    } resp_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [159:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [15:0]  m_tdata;

    sorted_range_table_lookup #(.TABLE_ENTRIES(DEPTH)) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Shadow copy of the range table.
    logic [63:0] shadow_base [DEPTH];
    logic [31:0] shadow_size [DEPTH];
    int          shadow_count;

    req_t  pending_reqs[$];
    resp_t expected_resps[$];
    int    fail_count;
    int    idle_cycles;
    bit    stim_done;
    int    send_gap;
    int    recv_gap;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Binary search exactly as the block does it; overlaps may be missed.
    function automatic logic search_shadow(logic [63:0] addr);
        int lo;
        int hi;
        int mid;
        logic [63:0] top;
        lo = 0;
        hi = shadow_count - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            top = shadow_base[mid] + {32'd0, shadow_size[mid]};
            if (addr >= shadow_base[mid] && addr < top) return 1'b1;
            if (addr < shadow_base[mid]) hi = mid - 1;
            else lo = mid + 1;
        end
        return 1'b0;
    endfunction

    function automatic resp_t table_step(req_t r);
        resp_t o;
        int pos;
        o.hit = 1'b0;
        o.status = ST_DONE;
        case (r.op)
            OP_CLEAR: begin
                shadow_count = 0;
            end
            OP_INSERT: begin
                if (r.base == 0 || r.size == 0) begin
                    o.status = ST_EMPTY;
                end else if (shadow_count >= DEPTH) begin
                    o.status = ST_FULL;
                end else begin
                    pos = shadow_count;
                    while (pos > 0 && shadow_base[pos-1] > r.base) pos--;
                    for (int k = shadow_count; k > pos; k--) begin
                        shadow_base[k] = shadow_base[k-1];
                        shadow_size[k] = shadow_size[k-1];
                    end
                    shadow_base[pos] = r.base;
                    shadow_size[pos] = r.size;
                    shadow_count++;
                end
            end
            OP_QUERY: begin
                o.hit = search_shadow(r.addr);
            end
            default: ;
        endcase
        o.held = shadow_count[8:0];
        return o;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push(op_t op, logic [63:0] base, logic [31:0] size, logic [63:0] addr);
        req_t r;
        r.op = op;
        r.base = base;
        r.size = size;
        r.addr = addr;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Stimulus.
    initial begin
        logic [63:0] b;
        logic [31:0] sz;
        int n;
        // directed: empty table, skipped inserts, extremes, unused op
        push(OP_QUERY, 0, 0, 64'd5);
        push(OP_INSERT, 64'd0, 32'd10, 0);
        push(OP_INSERT, 64'd100, 32'd0, 0);
        push(OP_INSERT, 64'd0, 32'd0, 0);
        push(OP_INSERT, 64'd100, 32'd16, 0);
        push(OP_INSERT, 64'd100, 32'd4, 0);   // equal base keeps arrival order
        push(OP_INSERT, 64'd50, 32'hFFFF_FFFF, 0);
        push(OP_INSERT, '1, 32'hFFFF_FFFF, 0); // sum wraps
        push(OP_INSERT, 64'h8000_0000_0000_0000, 32'd1, 0);
        push(OP_QUERY, 0, 0, 64'd0);
        push(OP_QUERY, 0, 0, 64'd100);
        push(OP_QUERY, 0, 0, 64'd115);
        push(OP_QUERY, 0, 0, 64'd116);
        push(OP_QUERY, 0, 0, '1);
        push(OP_QUERY, 0, 0, 64'h8000_0000_0000_0000);
        push(OP_QUERY, 0, 0, 64'h1_0000_0031);
        push(OP_NONE, '1, '1, '1);
        push(OP_CLEAR, '1, '1, '1);
        push(OP_QUERY, 0, 0, 64'd100);
        // fill past full so the drop case is reached
        for (int i = 0; i < DEPTH + 3; i++) begin
            push(OP_INSERT, rand64() | 64'd1, $urandom | 32'd1, 0);
        end
        for (int i = 0; i < 12; i++) push(OP_QUERY, 0, 0, rand64());
        push(OP_CLEAR, 0, 0, 0);
        // random: well-formed sessions of clear, build, query
        n = 0;
        while (n < 330) begin
            int fill;
            fill = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 12);
            b = ($urandom_range(0, 1)) ? {32'd0, $urandom} : rand64();
            for (int k = 0; k < fill; k++) begin
                case ($urandom_range(0, 9))
                    0: push(OP_INSERT, 0, $urandom, 0);
                    1: push(OP_INSERT, rand64(), 0, 0);
                    2: push(OP_INSERT, rand64(), $urandom, 0);
                    default: begin
                        b = b + $urandom_range(0, 4000) - 1500;
                        sz = $urandom_range(1, 2000);
                        if ($urandom_range(0, 15) == 0) sz = $urandom;
                        push(OP_INSERT, b, sz, 0);
                    end
                endcase
                n++;
            end
            for (int k = 0; k < $urandom_range(2, 10); k++) begin
                if ($urandom_range(0, 4) == 0) push(OP_QUERY, rand64(), $urandom, rand64());
                else push(OP_QUERY, rand64(), $urandom, b - $urandom_range(0, 6000));
                n++;
            end
            if ($urandom_range(0, 7) == 0) begin
                push(OP_NONE, rand64(), $urandom, rand64());
                n++;
            end
            if ($urandom_range(0, 2) != 0) begin
                push(OP_CLEAR, rand64(), $urandom, rand64());
                n++;
            end
        end
        stim_done = 1'b1;
    end

    // Driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (send_gap > 0 || pending_reqs.size() == 0) begin
                s_tvalid <= 1'b0;
                if (send_gap > 0) send_gap <= send_gap - 1;
            end else begin
                req_t r;
                r = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= r.op;
                s_tdata  <= {r.addr, r.size, r.base};
                expected_resps.push_back(table_step(r));
                send_gap <= pick_gap();
            end
        end
    end

    // Monitor and receiver stall.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
            idle_cycles <= 0;
        end else begin
            if (recv_gap > 0) begin
                m_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready) recv_gap <= pick_gap();
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_tvalid && m_tready) begin
                resp_t e;
                if (expected_resps.size() == 0) begin
                    $error("unexpected result transaction %h", m_tdata);
                    fail_count++;
                end else begin
                    e = expected_resps.pop_front();
                    if (m_tdata[0] !== e.hit) begin
                        $error("hit: expected %0d, got %0d", e.hit, m_tdata[0]);
                        fail_count++;
                    end
                    if (m_tdata[2:1] !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, m_tdata[2:1]);
                        fail_count++;
                    end
                    if (m_tdata[11:3] !== e.held) begin
                        $error("entries_held: expected %0d, got %0d", e.held, m_tdata[11:3]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Reset, end of run and watchdog.
    initial begin
        fail_count = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        shadow_count = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        while (!(stim_done && pending_reqs.size() == 0 && !s_tvalid
                 && expected_resps.size() == 0) && idle_cycles < IDLE_LIMIT)
            @(posedge aclk);
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("** sorted_range_table_lookup: FAILED **");
        end else begin
            repeat (40) @(posedge aclk);
            if (fail_count == 0) $display("** sorted_range_table_lookup: PASSED **");
            else $display("** sorted_range_table_lookup: FAILED **");
        end
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl
rtl/srtl_pkg.sv
rtl/srtl_cell.sv
rtl/srtl_search.sv
rtl/sorted_range_table_lookup.sv
tb/sv/tb.sv
